### rtl/core/acd_pkg.sv
// Package for the audio click detector: widths, register indexes and shared types.
// Has no dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package acd_pkg;

    localparam int NUM_CH      = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int SUM_W       = SAMPLE_BITS + 2;
    localparam int FRAC_BITS   = 8;
    localparam int SMOOTH_W    = SUM_W + FRAC_BITS;
    localparam int ALPHA_NUM   = 77;
    localparam int ALPHA_W     = 7;
    localparam int CNT_W       = 32;
    localparam int CC_W        = 3;
    localparam int THR_W       = 18;
    localparam int DEB_W       = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CC_W-1:0]  CC_RESET       = CC_W'(2);
    localparam logic [THR_W-1:0] JUMP_THR_RESET = THR_W'(4096);
    localparam logic [THR_W-1:0] SLOPE_THR_RESET = THR_W'(4096);
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(4800);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 2'd0,
        CFG_JUMP_THR      = 2'd1,
        CFG_SLOPE_THR     = 2'd2,
        CFG_DEBOUNCE      = 2'd3
    } t_cfg_index;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef struct packed {
        logic level_jump;
        logic slope_jump;
        logic crack_event;
        logic crack_latched;
    } t_flags;

endpackage

### rtl/core/audio_click_detector.sv
// Top level of the audio click detector: config registers, beat control, lanes and core.
// Depends on acd_pkg, acd_merge and acd_detect.
`timescale 1ns / 1ps

// Takes one frame of four signed Q1.15 channel samples per beat and returns one
// beat of four flags per frame. Throughput is one frame per clock while the output
// is not stalled; a result beat moves from the stage-one register into the output
// register and waits there until taken. Stage one holds the per-channel lanes and
// the adder that merges them into the frame sum; stage two is the detector core, and
// its combinational loop (difference, deviation, multiply by 77/256 and add back into
// the smoothed slope) is what sets the clock period. The output beat sits in its own
// register, so a new frame is taken while a result waits for the downstream side;
// with both stages full and the output stalled, o_in_ready drops. Write configuration
// only while no frame is in flight. channel_count above four sums all four channels,
// zero gives a sum of zero. The crack latch, the frame counter (saturating) and the
// debounce origin clear only at reset.
module audio_click_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [15:0]                i_sample_ch0,
    input  logic signed [15:0]                i_sample_ch1,
    input  logic signed [15:0]                i_sample_ch2,
    input  logic signed [15:0]                i_sample_ch3,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_level_jump,
    output logic                              o_slope_jump,
    output logic                              o_crack_event,
    output logic                              o_crack_latched,
    input  logic                              i_cfg_we,
    input  logic [acd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [acd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import acd_pkg::*;

    logic [CC_W-1:0]   r_channel_count;
    logic [THR_W-1:0]  r_jump_thr;
    logic [THR_W-1:0]  r_slope_thr;
    logic [DEB_W-1:0]  r_debounce;

    logic              r_s1_valid;
    logic              r_out_valid;
    logic              s1_load;
    logic              s2_load;
    logic              core_load;

    t_sample [3:0]     samples;
    t_sum              frame_sum;
    t_flags            flags;
    logic              crack_flag;

    // Configuration: plain write, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CC_RESET;
            r_jump_thr      <= JUMP_THR_RESET;
            r_slope_thr     <= SLOPE_THR_RESET;
            r_debounce      <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[CC_W-1:0];
                CFG_JUMP_THR:      r_jump_thr      <= i_cfg_data[THR_W-1:0];
                CFG_SLOPE_THR:     r_slope_thr     <= i_cfg_data[THR_W-1:0];
                CFG_DEBOUNCE:      r_debounce      <= i_cfg_data[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Beat control: the output register loads when empty or drained this cycle;
    // stage one advances into it, and takes a new beat whenever it has room.
    assign s2_load    = !r_out_valid || i_out_ready;
    assign core_load  = r_s1_valid && s2_load;
    assign o_in_ready = !r_s1_valid || s2_load;
    assign s1_load    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s2_load) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign samples = {i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};

    // Stage one: gate each channel in its lane and merge into the frame sum
    acd_merge u_merge (
        .i_clk           (i_clk),
        .i_load          (s1_load),
        .i_samples       (samples),
        .i_channel_count (r_channel_count),
        .o_sum           (frame_sum)
    );

    // Stage two: compares, smoothing, debounce; flags land in the output register
    acd_detect u_detect (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (core_load),
        .i_sum        (frame_sum),
        .i_jump_thr   (r_jump_thr),
        .i_slope_thr  (r_slope_thr),
        .i_debounce   (r_debounce),
        .o_flags      (flags),
        .o_crack_flag (crack_flag)
    );

    assign o_out_valid     = r_out_valid;
    assign o_level_jump    = flags.level_jump;
    assign o_slope_jump    = flags.slope_jump;
    assign o_crack_event   = flags.crack_event;
    assign o_crack_latched = flags.crack_latched;

    // The crack latch never clears outside reset
    a_latch_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        crack_flag |=> crack_flag)
        else $error("crack latch cleared");

    // A reported crack always shows the latch set in the same beat
    a_event_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_crack_event) |-> o_crack_latched)
        else $error("crack event without latch");

    // Input stalls only when stage one is full and cannot drain
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room available");

    // A result beat appears only after a frame went through the core
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(core_load))
        else $error("output beat without a frame");

endmodule

### rtl/core/acd_lane.sv
// One channel lane: sign-extend a sample and gate it by the active channel count.
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_lane (
    input  acd_pkg::t_sample i_sample,
    input  logic             i_lane_on,
    output acd_pkg::t_sum    o_term
);
    import acd_pkg::*;

    // drop inactive channels, widen active ones to sum width
    assign o_term = i_lane_on ? t_sum'(i_sample) : '0;

endmodule

### rtl/core/acd_merge.sv
// Lanes and merge stage: one lane per channel, adder tree, registered frame sum.
// Depends on acd_pkg and acd_lane.
`timescale 1ns / 1ps

module acd_merge (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  acd_pkg::t_sample [3:0]       i_samples,
    input  logic [acd_pkg::CC_W-1:0]     i_channel_count,
    output acd_pkg::t_sum                o_sum
);
    import acd_pkg::*;

    t_sum         terms [NUM_CH];
    t_sum         pair_a;
    t_sum         pair_b;
    t_sum         r_sum;

    for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
        acd_lane u_lane (
            .i_sample  (i_samples[k]),
            .i_lane_on (i_channel_count > CC_W'(k)),
            .o_term    (terms[k])
        );
    end

    // two-level tree; four full-scale samples fit the sum width
    assign pair_a = terms[0] + terms[1];
    assign pair_b = terms[2] + terms[3];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= pair_a + pair_b;
        end
    end

    assign o_sum = r_sum;

endmodule

### rtl/core/acd_detect.sv
// Detector core: level and slope compares, smoothed slope, debounce and crack latch.
// Depends on acd_pkg.
`timescale 1ns / 1ps

module acd_detect (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  acd_pkg::t_sum                i_sum,
    input  logic [acd_pkg::THR_W-1:0]    i_jump_thr,
    input  logic [acd_pkg::THR_W-1:0]    i_slope_thr,
    input  logic [acd_pkg::DEB_W-1:0]    i_debounce,
    output acd_pkg::t_flags              o_flags,
    output logic                         o_crack_flag
);
    import acd_pkg::*;

    localparam int PROD_W = SMOOTH_W + 1 + ALPHA_W + 1;

    t_sum                        r_prev_sum;
    logic [SMOOTH_W-1:0]         r_smooth;
    logic [CNT_W-1:0]            r_frame_cnt;
    logic [CNT_W-1:0]            r_crack_time;
    logic                        r_crack_flag;
    t_flags                      r_flags;

    logic signed [SUM_W:0]       diff;
    logic [SUM_W-1:0]            mag;
    logic [SMOOTH_W-1:0]         target;
    logic signed [SMOOTH_W:0]    err;
    logic [SMOOTH_W-1:0]         dev;
    logic signed [PROD_W-1:0]    prod;
    logic signed [PROD_W-1:0]    step;
    logic [CNT_W-1:0]            elapsed;
    logic                        level;
    logic                        slope;
    logic                        crack;
    logic [SMOOTH_W-1:0]         n_smooth;
    logic [CNT_W-1:0]            n_frame_cnt;

    always_comb begin
        diff    = (SUM_W+1)'(i_sum) - (SUM_W+1)'(r_prev_sum);
        mag     = diff[SUM_W] ? SUM_W'(-diff) : SUM_W'(diff);
        target  = {mag, FRAC_BITS'(0)};
        err     = $signed({1'b0, target}) - $signed({1'b0, r_smooth});
        dev     = err[SMOOTH_W] ? SMOOTH_W'(-err) : SMOOTH_W'(err);
        level   = mag > SUM_W'(i_jump_thr);
        slope   = dev > {i_slope_thr, FRAC_BITS'(0)};
        elapsed = r_frame_cnt - r_crack_time;
        crack   = (level || slope) && (elapsed > CNT_W'(i_debounce));
        // arithmetic shift floors toward minus infinity
        prod    = PROD_W'(err) * $signed(PROD_W'(ALPHA_NUM));
        step    = prod >>> FRAC_BITS;
        n_smooth    = r_smooth + step[SMOOTH_W-1:0];
        n_frame_cnt = (&r_frame_cnt) ? r_frame_cnt : r_frame_cnt + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sum   <= '0;
            r_smooth     <= '0;
            r_frame_cnt  <= '0;
            r_crack_time <= '0;
            r_crack_flag <= 1'b0;
        end else if (i_load) begin
            r_prev_sum  <= i_sum;
            r_smooth    <= n_smooth;
            r_frame_cnt <= n_frame_cnt;
            if (crack) begin
                // only the first crack sets the debounce origin
                if (!r_crack_flag) begin
                    r_crack_time <= r_frame_cnt;
                end
                r_crack_flag <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= '{level_jump:    level,
                         slope_jump:    slope,
                         crack_event:   crack,
                         crack_latched: r_crack_flag || crack};
        end
    end

    assign o_flags      = r_flags;
    assign o_crack_flag = r_crack_flag;

endmodule
